/* rtl/ppe_pkg.sv */
package ppe_pkg;

  localparam int NUM_TYPES_DEF = 4;
  localparam int TYPE_W        = 2;
  localparam int DIST_W        = 16;
  localparam int WORD_W        = 16;
  localparam int CORE_W        = 37;
  localparam int ENERGY_W      = 40;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_W         = 37;
  localparam int HARD_W        = 17;
  localparam int MF_W          = 18;
  localparam int DIV_W         = 17;
  localparam int QUO_W         = 38;
  localparam int NUM_W         = 55;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CMD_EVAL   = 2'd0;
  localparam logic [1:0] CMD_RADIUS = 2'd1;
  localparam logic [1:0] CMD_DEPTH  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CORE   = 2'd2;

  localparam logic [DIST_W-1:0] CUTOFF_RST = 16'd512;
  localparam logic [DIST_W-1:0] LENGTH_RST = 16'd256;
  localparam logic [CORE_W-1:0] CORE_RST   = 37'd2560000000;

  // one classified evaluation: product a*mfac divided by divisor, sign applied last
  typedef struct packed {
    logic              is_core;
    logic              neg;
    logic [WORD_W-1:0] mag;
    logic [MF_W-1:0]   mfac;
    logic [DIV_W-1:0]  divisor;
  } ppe_job_t;

endpackage

/* rtl/pair_potential_eval_top.sv */
// triangle-well pair potential with a hard core, Q8.8 in, signed Q31.8 out.
// cmd 0 evaluates (type_a, type_b, distance) and gives one item; cmd 1 loads a
// radius, cmd 2 a well depth, neither gives a result. one item is taken every
// cycle while in_full is low; an evaluation passes the front's lookup register,
// is classified into the job queue, then passes the multiply register, the
// divider's operand load and its 38 one-bit stages, and one output register.
// the back end holds as a whole while a result waits to be popped; the 4-entry
// job queue lets the front keep taking items meanwhile. tables read as zero until written
// after reset. the user writes configuration only while the block is idle, unchecked.
module pair_potential_eval_top #(
  parameter int NUM_TYPES = ppe_pkg::NUM_TYPES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [1:0]                      in_cmd,
  input  logic [ppe_pkg::TYPE_W-1:0]      in_type_a,
  input  logic [ppe_pkg::TYPE_W-1:0]      in_type_b,
  input  logic [ppe_pkg::DIST_W-1:0]      in_distance,
  input  logic [ppe_pkg::WORD_W-1:0]      in_table_word,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [ppe_pkg::ENERGY_W-1:0]    out_pair_energy,
  input  logic                            cfg_we,
  input  logic [ppe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ppe_pkg::CFG_W-1:0]       cfg_data
);
  import ppe_pkg::*;

  logic [DIST_W-1:0] cutoff_r, length_r;
  logic [CORE_W-1:0] core_r;

  logic              job_push, job_valid, job_take;
  ppe_job_t          job_in, job_out;
  logic [QCNT_W-1:0] q_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= CUTOFF_RST;
      length_r <= LENGTH_RST;
      core_r   <= CORE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CUTOFF: cutoff_r <= cfg_data[DIST_W-1:0];
        CFG_LENGTH: length_r <= cfg_data[DIST_W-1:0];
        CFG_CORE:   core_r   <= cfg_data[CORE_W-1:0];
        default: ;
      endcase
    end
  end

  // front: tables, lookup, classify
  ppe_front #(.NUM_TYPES(NUM_TYPES)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_cmd        (in_cmd),
    .in_type_a     (in_type_a),
    .in_type_b     (in_type_b),
    .in_distance   (in_distance),
    .in_table_word (in_table_word),
    .cutoff        (cutoff_r),
    .length        (length_r),
    .q_count       (q_count),
    .job_push      (job_push),
    .job           (job_in)
  );

  // job queue decouples front from back
  ppe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .wr_job   (job_in),
    .pop      (job_take),
    .nonempty (job_valid),
    .rd_job   (job_out),
    .count    (q_count)
  );

  // back: multiply, divide, sign, output register
  ppe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (job_valid),
    .job             (job_out),
    .job_take        (job_take),
    .core_energy     (core_r),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_pair_energy (out_pair_energy)
  );

endmodule

/* rtl/ppe_front.sv */
module ppe_front #(
  parameter int NUM_TYPES = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [1:0]                  in_cmd,
  input  logic [ppe_pkg::TYPE_W-1:0]  in_type_a,
  input  logic [ppe_pkg::TYPE_W-1:0]  in_type_b,
  input  logic [ppe_pkg::DIST_W-1:0]  in_distance,
  input  logic [ppe_pkg::WORD_W-1:0]  in_table_word,
  input  logic [ppe_pkg::DIST_W-1:0]  cutoff,
  input  logic [ppe_pkg::DIST_W-1:0]  length,
  input  logic [ppe_pkg::QCNT_W-1:0]  q_count,
  output logic                        job_push,
  output ppe_pkg::ppe_job_t           job
);
  import ppe_pkg::*;

  localparam int IW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int NE = NUM_TYPES * NUM_TYPES;
  localparam int EW = (NE > 1) ? $clog2(NE) : 1;

  logic [WORD_W-1:0] rad_mem [NUM_TYPES];
  logic [WORD_W-1:0] dep_mem [NE];
  logic [NUM_TYPES-1:0] rad_vld_r;
  logic [NE-1:0]        dep_vld_r;

  logic              accept, oka, okb;
  logic [IW-1:0]     ia, ib;
  logic [EW-1:0]     ie;

  logic              a_valid_r;
  logic [DIST_W-1:0] dist_r;
  logic [WORD_W-1:0] ra_r, rb_r, dp_r;
  logic              va_r, vb_r, vd_r;

  logic [WORD_W-1:0] ra, rb, dp;
  logic [HARD_W-1:0] hard, gap, dist17;
  logic              core_hit, well_hit, in_cut;
  logic [WORD_W-1:0] w;

  assign in_full = ({1'b0, q_count} + {{QCNT_W{1'b0}}, a_valid_r})
                   >= (QCNT_W+1)'(QUEUE_DEPTH);
  assign accept  = in_push && !in_full;
  assign oka     = 32'(in_type_a) < NUM_TYPES;
  assign okb     = 32'(in_type_b) < NUM_TYPES;
  assign ia      = IW'(in_type_a);
  assign ib      = IW'(in_type_b);
  assign ie      = EW'(32'(in_type_a) * NUM_TYPES + 32'(in_type_b));

  always_ff @(posedge clk) begin
    if (accept && in_cmd == CMD_RADIUS && oka) begin
      rad_mem[ia] <= in_table_word;
    end
    if (accept && in_cmd == CMD_DEPTH && oka && okb) begin
      dep_mem[ie] <= in_table_word;
    end
    ra_r   <= rad_mem[ia];
    rb_r   <= rad_mem[ib];
    dp_r   <= dep_mem[ie];
    va_r   <= oka && rad_vld_r[ia];
    vb_r   <= okb && rad_vld_r[ib];
    vd_r   <= oka && okb && dep_vld_r[ie];
    dist_r <= in_distance;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_vld_r <= '0;
      dep_vld_r <= '0;
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= accept && in_cmd == CMD_EVAL;
      if (accept && in_cmd == CMD_RADIUS && oka) begin
        rad_vld_r[ia] <= 1'b1;
      end
      if (accept && in_cmd == CMD_DEPTH && oka && okb) begin
        dep_vld_r[ie] <= 1'b1;
      end
    end
  end

  // classify: core, well or zero
  always_comb begin
    ra       = va_r ? ra_r : '0;
    rb       = vb_r ? rb_r : '0;
    dp       = vd_r ? dp_r : '0;
    hard     = HARD_W'(ra) + HARD_W'(rb);
    dist17   = HARD_W'(dist_r);
    in_cut   = dist_r < cutoff;
    core_hit = dist17 < hard;
    gap      = dist17 - hard;
    well_hit = !core_hit && (gap < HARD_W'(length));
    w        = length - gap[WORD_W-1:0];

    job         = '0;
    job.divisor = DIV_W'(1);
    if (in_cut && core_hit) begin
      job.is_core = 1'b1;
      job.mfac    = {hard, 1'b0} - MF_W'(dist_r);
      job.divisor = hard;
    end else if (in_cut && well_hit) begin
      job.neg     = dp[WORD_W-1];
      job.mag     = dp[WORD_W-1] ? (WORD_W'(0) - dp) : dp;
      job.mfac    = MF_W'(w);
      job.divisor = DIV_W'(length);
    end
  end

  assign job_push = a_valid_r;

endmodule

/* rtl/ppe_queue.sv */
module ppe_queue #(
  parameter int DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  ppe_pkg::ppe_job_t           wr_job,
  input  logic                        pop,
  output logic                        nonempty,
  output ppe_pkg::ppe_job_t           rd_job,
  output logic [$clog2(DEPTH+1)-1:0]  count
);
  import ppe_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ppe_job_t        slot_r [DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;
  logic            do_pop;

  assign do_pop   = pop && (cnt_r != '0);
  assign nonempty = cnt_r != '0;
  assign rd_job   = slot_r[rp_r];
  assign count    = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (32'(wp_r) == DEPTH - 1) ? '0 : wp_r + PW'(1);
      end
      if (do_pop) begin
        rp_r <= (32'(rp_r) == DEPTH - 1) ? '0 : rp_r + PW'(1);
      end
      cnt_r <= cnt_r + CW'(push) - CW'(do_pop);
    end
  end

endmodule

/* rtl/ppe_back.sv */
module ppe_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  input  ppe_pkg::ppe_job_t             job,
  output logic                          job_take,
  input  logic [ppe_pkg::CORE_W-1:0]    core_energy,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [ppe_pkg::ENERGY_W-1:0]  out_pair_energy
);
  import ppe_pkg::*;

  logic              en;
  logic              m_v_r, m_neg_r;
  logic [NUM_W-1:0]  prod_r;
  logic [DIV_W-1:0]  m_div_r;
  logic [CORE_W-1:0] opa;

  logic              v_r   [QUO_W+1];
  logic              neg_r [QUO_W+1];
  logic [DIV_W-1:0]  rem_r [QUO_W+1];
  logic [DIV_W-1:0]  dv_r  [QUO_W+1];
  logic [QUO_W-1:0]  low_r [QUO_W+1];
  logic [QUO_W-1:0]  quo_r [QUO_W+1];

  logic [DIV_W-1:0]  rem_nxt [QUO_W+1];
  logic [QUO_W-1:0]  quo_nxt [QUO_W+1];
  logic [DIV_W:0]    trial   [QUO_W+1];
  logic              ge      [QUO_W+1];

  logic              out_valid_r;
  logic [ENERGY_W-1:0] out_r;

  // whole back end moves together, held only by a waiting result
  assign en       = !out_valid_r || out_pop;
  assign job_take = en && job_valid;
  assign opa      = job.is_core ? core_energy : CORE_W'(job.mag);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= {{(NUM_W-CORE_W){1'b0}}, opa} * {{(NUM_W-MF_W){1'b0}}, job.mfac};
      m_div_r <= job.divisor;
      m_neg_r <= job.neg;
    end
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    rem_nxt[0] = '0;
    quo_nxt[0] = '0;
    trial[0]   = '0;
    ge[0]      = 1'b0;
    for (int k = 1; k <= QUO_W; k++) begin
      trial[k]   = {rem_r[k-1], low_r[k-1][QUO_W-1]};
      ge[k]      = trial[k] >= {1'b0, dv_r[k-1]};
      rem_nxt[k] = ge[k] ? DIV_W'(trial[k] - {1'b0, dv_r[k-1]}) : trial[k][DIV_W-1:0];
      quo_nxt[k] = {quo_r[k-1][QUO_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= prod_r[NUM_W-1:QUO_W];
      low_r[0] <= prod_r[QUO_W-1:0];
      quo_r[0] <= '0;
      dv_r[0]  <= m_div_r;
      neg_r[0] <= m_neg_r;
      for (int k = 1; k <= QUO_W; k++) begin
        rem_r[k] <= rem_nxt[k];
        low_r[k] <= {low_r[k-1][QUO_W-2:0], 1'b0};
        quo_r[k] <= quo_nxt[k];
        dv_r[k]  <= dv_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
      out_r <= neg_r[QUO_W] ? (ENERGY_W'(0) - ENERGY_W'(quo_r[QUO_W]))
                            : ENERGY_W'(quo_r[QUO_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= QUO_W; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      m_v_r       <= job_valid;
      v_r[0]      <= m_v_r;
      for (int k = 1; k <= QUO_W; k++) begin
        v_r[k] <= v_r[k-1];
      end
      out_valid_r <= v_r[QUO_W];
    end
  end

  assign out_empty       = !out_valid_r;
  assign out_pair_energy = out_r;

endmodule

/* rtl/ppe_checker.sv */
module ppe_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_full,
  input logic                            out_empty,
  input logic                            out_pop,
  input logic [ppe_pkg::ENERGY_W-1:0]    out_pair_energy
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_reset_room: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_pair_energy)))
    else $error("waiting result changed or dropped");

endmodule

bind pair_potential_eval_top ppe_checker u_ppe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_full         (in_full),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_pair_energy (out_pair_energy)
);
